@@ rtl/core/smoc_pkg.sv @@
// Shared constants and types for the stat map overlay colorizer.
package smoc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 48;
  localparam int CH_BITS    = 8;
  localparam int NUM_CH     = 3;
  localparam int CFG_IDX_W  = 3;

  // Blend product: unsigned fraction (FRAC_BITS+1) times signed channel difference (CH_BITS+1).
  localparam int PROD_W = FRAC_BITS + CH_BITS + 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_TAILED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SIGN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SUB    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COLORS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_COLORS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_COLORS   = 3'd7;

  // Reset values.
  localparam logic [VALUE_BITS-2:0] THRESHOLD_RST  = (VALUE_BITS-1)'(1) << FRAC_BITS;
  localparam logic [COLOR_BITS-1:0] POS_COLORS_RST = 48'd280375481859840;
  localparam logic [COLOR_BITS-1:0] NEG_COLORS_RST = 48'd3362022655;
  localparam logic [COLOR_BITS-1:0] NS_COLORS_RST  = 48'd3357474590;

  // Control that rides along with an item through the pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  blank;
    logic                  one;
    logic [COLOR_BITS-1:0] pair;
  } smoc_ctl_t;

endpackage

@@ rtl/core/stat_map_overlay_colorizer_unit.sv @@
// Top level of the stat map overlay colorizer: fixed-point value to overlay pixel.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+-----------------------------
//  input   | in_value                                         | start high, busy low
//  result  | out_red, out_green, out_blue, out_visible        | out_valid strobe, one cycle
//  config  | cfg_index, cfg_data                              | cfg_we, write at the edge
//
// An item enters on every cycle; busy is always low. Items pass through stages I, A,
// B, C, the restoring divider that yields one fraction bit per stage, M and O. Reset
// clears the configuration to its defaults and every valid bit in the pipeline;
// payload registers are not reset. The receiver cannot stall, so the pipeline
// advances on every clock and each result is shown for exactly one cycle.
module stat_map_overlay_colorizer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [smoc_pkg::VALUE_BITS-1:0] in_value,
  output logic                                out_valid,
  output logic [smoc_pkg::CH_BITS-1:0]        out_red,
  output logic [smoc_pkg::CH_BITS-1:0]        out_green,
  output logic [smoc_pkg::CH_BITS-1:0]        out_blue,
  output logic                                out_visible,
  input  logic                                cfg_we,
  input  logic [smoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smoc_pkg::COLOR_BITS-1:0]     cfg_data
);

  localparam int VB   = smoc_pkg::VALUE_BITS;
  localparam int FB   = smoc_pkg::FRAC_BITS;
  localparam int CB   = smoc_pkg::CH_BITS;
  localparam int NCH  = smoc_pkg::NUM_CH;
  localparam int PW   = smoc_pkg::PROD_W;
  localparam int COLW = smoc_pkg::COLOR_BITS;
  localparam int HALF = COLW / 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VB-2:0]        thr_r;
  logic signed [VB-1:0] high_r;
  logic                 two_tailed_r;
  logic                 flip_r;
  logic                 show_sub_r;
  logic [COLW-1:0]      pos_r;
  logic [COLW-1:0]      neg_r;
  logic [COLW-1:0]      ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= smoc_pkg::THRESHOLD_RST;
      high_r       <= '0;
      two_tailed_r <= 1'b1;
      flip_r       <= 1'b0;
      show_sub_r   <= 1'b0;
      pos_r        <= smoc_pkg::POS_COLORS_RST;
      neg_r        <= smoc_pkg::NEG_COLORS_RST;
      ns_r         <= smoc_pkg::NS_COLORS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        smoc_pkg::CFG_THRESHOLD:  thr_r        <= cfg_data[VB-2:0];
        smoc_pkg::CFG_HIGH_LEVEL: high_r       <= cfg_data[VB-1:0];
        smoc_pkg::CFG_TWO_TAILED: two_tailed_r <= cfg_data[0];
        smoc_pkg::CFG_FLIP_SIGN:  flip_r       <= cfg_data[0];
        smoc_pkg::CFG_SHOW_SUB:   show_sub_r   <= cfg_data[0];
        smoc_pkg::CFG_POS_COLORS: pos_r        <= cfg_data;
        smoc_pkg::CFG_NEG_COLORS: neg_r        <= cfg_data;
        smoc_pkg::CFG_NS_COLORS:  ns_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline never holds an item off.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage I: capture the input item
  // ---------------------------------------------------------------------------
  logic                 i_valid_r;
  logic signed [VB-1:0] i_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
    end else begin
      i_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    i_value_r <= in_value;
  end

  // ---------------------------------------------------------------------------
  // Stage A: sign after the optional flip, and magnitude. The magnitude of the
  // flipped value equals that of the raw one, so one negation suffices; the
  // most negative value gives 2^(VB-1), which still fits VB unsigned bits.
  // ---------------------------------------------------------------------------
  logic          a_valid_r, a_valid_nxt;
  logic          a_neg_r,   a_neg_nxt;
  logic [VB-1:0] a_mag_r,   a_mag_nxt;

  always_comb begin
    logic raw_neg;
    logic raw_nz;
    raw_neg     = i_value_r[VB-1];
    raw_nz      = |i_value_r;
    a_valid_nxt = i_valid_r;
    a_neg_nxt   = flip_r ? (!raw_neg && raw_nz) : raw_neg;
    a_mag_nxt   = raw_neg ? (~i_value_r + VB'(1)) : i_value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r <= a_neg_nxt;
    a_mag_r <= a_mag_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage B: classify against the threshold, pick the color pair and set up
  // numerator and denominator of the blend fraction.
  // ---------------------------------------------------------------------------
  smoc_pkg::smoc_ctl_t b_ctl_r, b_ctl_nxt;
  logic [VB-1:0]       b_num_r, b_num_nxt;
  logic [VB-1:0]       b_den_r, b_den_nxt;

  always_comb begin
    logic [VB-1:0] thr_ext;
    logic          above;
    logic          high_le;
    thr_ext  = {1'b0, thr_r};
    above    = a_mag_r > thr_ext;
    high_le  = high_r <= $signed(thr_ext);

    b_ctl_nxt.valid = a_valid_r;
    b_ctl_nxt.blank = (!two_tailed_r && a_neg_r) || (a_mag_r == '0)
                      || (!above && !show_sub_r);
    b_ctl_nxt.one   = above && high_le;
    if (above) begin
      b_ctl_nxt.pair = a_neg_r ? neg_r : pos_r;
    end else begin
      b_ctl_nxt.pair = ns_r;
    end
    b_num_nxt = above ? (a_mag_r - thr_ext) : a_mag_r;
    b_den_nxt = above ? (high_r - thr_ext) : thr_ext;
  end

  // Reset only the valid bit; the payload fields advance freely.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r.valid <= 1'b0;
    end else begin
      b_ctl_r.valid <= b_ctl_nxt.valid;
    end
    b_ctl_r.blank <= b_ctl_nxt.blank;
    b_ctl_r.one   <= b_ctl_nxt.one;
    b_ctl_r.pair  <= b_ctl_nxt.pair;
    b_num_r       <= b_num_nxt;
    b_den_r       <= b_den_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage C and divider stages: clamp to 1.0 when num >= den, then one
  // restoring-division step per stage for FB fraction bits. Entry 0 is stage C.
  // The remainder stays below den < 2^(VB-1), so dropping its top bit on the
  // shift loses nothing; on clamped items the quotient is ignored.
  // ---------------------------------------------------------------------------
  smoc_pkg::smoc_ctl_t d_ctl_r [FB+1];
  logic [VB-1:0]       d_rem_r [FB+1];
  logic [VB-1:0]       d_den_r [FB+1];
  logic [FB-1:0]       d_q_r   [FB+1];

  smoc_pkg::smoc_ctl_t d_ctl_nxt [FB+1];
  logic [VB-1:0]       d_rem_nxt [FB+1];
  logic [VB-1:0]       d_den_nxt [FB+1];
  logic [FB-1:0]       d_q_nxt   [FB+1];

  always_comb begin
    logic [VB-1:0] shifted;
    logic          take;
    d_ctl_nxt[0]     = b_ctl_r;
    d_ctl_nxt[0].one = b_ctl_r.one || (b_num_r >= b_den_r);
    d_rem_nxt[0]     = b_num_r;
    d_den_nxt[0]     = b_den_r;
    d_q_nxt[0]       = '0;
    for (int k = 1; k <= FB; k++) begin
      shifted      = {d_rem_r[k-1][VB-2:0], 1'b0};
      take         = shifted >= d_den_r[k-1];
      d_ctl_nxt[k] = d_ctl_r[k-1];
      d_den_nxt[k] = d_den_r[k-1];
      d_rem_nxt[k] = take ? (shifted - d_den_r[k-1]) : shifted;
      d_q_nxt[k]   = {d_q_r[k-1][FB-2:0], take};
    end
  end

  // Reset only the valid bits; the payload fields advance freely.
  always_ff @(posedge clk) begin
    for (int k = 0; k <= FB; k++) begin
      if (!rst_n) begin
        d_ctl_r[k].valid <= 1'b0;
      end else begin
        d_ctl_r[k].valid <= d_ctl_nxt[k].valid;
      end
      d_ctl_r[k].blank <= d_ctl_nxt[k].blank;
      d_ctl_r[k].one   <= d_ctl_nxt[k].one;
      d_ctl_r[k].pair  <= d_ctl_nxt[k].pair;
      d_rem_r[k]       <= d_rem_nxt[k];
      d_den_r[k]       <= d_den_nxt[k];
      d_q_r[k]         <= d_q_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: fraction times (end - start) for each channel, red first.
  // ---------------------------------------------------------------------------
  logic                 m_valid_r;
  logic                 m_blank_r;
  logic [CB-1:0]        m_start_r [NCH];
  logic signed [PW-1:0] m_prod_r  [NCH];
  logic signed [PW-1:0] m_prod_nxt [NCH];
  logic [CB-1:0]        m_start_nxt [NCH];

  always_comb begin
    logic [FB:0]          frac;
    logic [CB-1:0]        s_ch;
    logic [CB-1:0]        e_ch;
    logic signed [CB:0]   diff;
    logic signed [PW-1:0] f_ext;
    logic signed [PW-1:0] d_ext;
    frac = d_ctl_r[FB].one ? ((FB+1)'(1) << FB) : {1'b0, d_q_r[FB]};
    for (int c = 0; c < NCH; c++) begin
      s_ch  = d_ctl_r[FB].pair[HALF + (NCH-1-c)*CB +: CB];
      e_ch  = d_ctl_r[FB].pair[(NCH-1-c)*CB +: CB];
      diff  = $signed({1'b0, e_ch}) - $signed({1'b0, s_ch});
      f_ext = $signed({{(PW-FB-1){1'b0}}, frac});
      d_ext = {{(PW-CB-1){diff[CB]}}, diff};
      m_prod_nxt[c]  = f_ext * d_ext;
      m_start_nxt[c] = s_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= d_ctl_r[FB].valid;
    end
  end

  always_ff @(posedge clk) begin
    m_blank_r <= d_ctl_r[FB].blank;
    for (int c = 0; c < NCH; c++) begin
      m_prod_r[c]  <= m_prod_nxt[c];
      m_start_r[c] <= m_start_nxt[c];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage O: truncate the product toward zero, add to the start color, and
  // drive the result registers. A blank pixel has all channels zero.
  // ---------------------------------------------------------------------------
  logic          out_valid_r;
  logic          out_visible_r;
  logic [CB-1:0] out_ch_r   [NCH];
  logic [CB-1:0] out_ch_nxt [NCH];

  always_comb begin
    logic [PW-1:0] pmag;
    logic [CB:0]   step;
    logic [CB:0]   sum;
    for (int c = 0; c < NCH; c++) begin
      pmag = m_prod_r[c][PW-1] ? (~m_prod_r[c] + PW'(1)) : m_prod_r[c];
      step = pmag[FB +: CB+1];
      if (m_prod_r[c][PW-1]) begin
        sum = {1'b0, m_start_r[c]} - step;
      end else begin
        sum = {1'b0, m_start_r[c]} + step;
      end
      out_ch_nxt[c] = m_blank_r ? '0 : sum[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= !m_blank_r;
    for (int c = 0; c < NCH; c++) begin
      out_ch_r[c] <= out_ch_nxt[c];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_ch_r[0];
  assign out_green   = out_ch_r[1];
  assign out_blue    = out_ch_r[2];
  assign out_visible = out_visible_r;

endmodule

@@ tb/stat_map_overlay_colorizer_unit_tb.sv @@
// Self-checking testbench for the stat map overlay colorizer: directed table, then random phases.
module stat_map_overlay_colorizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = smoc_pkg::VALUE_BITS;
  localparam int FRAC_BITS  = smoc_pkg::FRAC_BITS;
  localparam int CH_BITS    = smoc_pkg::CH_BITS;
  localparam int CFG_IDX_W  = smoc_pkg::CFG_IDX_W;
  localparam int COLOR_BITS = smoc_pkg::COLOR_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = smoc_pkg::CFG_THRESHOLD;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL = smoc_pkg::CFG_HIGH_LEVEL;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_TAILED = smoc_pkg::CFG_TWO_TAILED;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SIGN  = smoc_pkg::CFG_FLIP_SIGN;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SUB   = smoc_pkg::CFG_SHOW_SUB;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COLORS = smoc_pkg::CFG_POS_COLORS;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_COLORS = smoc_pkg::CFG_NEG_COLORS;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_COLORS  = smoc_pkg::CFG_NS_COLORS;

  localparam logic [VALUE_BITS-2:0] THRESHOLD_RST  = smoc_pkg::THRESHOLD_RST;
  localparam logic [COLOR_BITS-1:0] POS_COLORS_RST = smoc_pkg::POS_COLORS_RST;
  localparam logic [COLOR_BITS-1:0] NEG_COLORS_RST = smoc_pkg::NEG_COLORS_RST;
  localparam logic [COLOR_BITS-1:0] NS_COLORS_RST  = smoc_pkg::NS_COLORS_RST;

  // Depth of the DUT pipeline, stages I through O; the final drain outlasts it.
  localparam int LATENCY = FRAC_BITS + 6;
  // Generous cycle cap, well above what 1946 items need at the longest sender gap.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               visible;
  } pixel_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table. Index and data matter on register rows only;
  // value, fixed and px matter on item rows only. fixed marks a hand-typed result.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [COLOR_BITS-1:0]   data;
    logic [VALUE_BITS-1:0]   value;
    logic                    fixed;
    pixel_t                  px;
  } stim_row_t;

  // Shadow copy of the configuration registers.
  typedef struct {
    logic [VALUE_BITS-2:0]   thr;
    logic [VALUE_BITS-1:0]   high;
    logic                    two_tailed;
    logic                    flip;
    logic                    show_sub;
    logic [COLOR_BITS-1:0]   pos;
    logic [COLOR_BITS-1:0]   neg;
    logic [COLOR_BITS-1:0]   ns;
  } overlay_cfg_t;

  localparam pixel_t PX_BLANK = '{8'd0, 8'd0, 8'd0, 1'b0};
  // Drawn, but with every channel at zero.
  localparam pixel_t PX_DARK  = '{8'd0, 8'd0, 8'd0, 1'b1};
  // End colors of the reset pairs: positive yellow, negative light blue, sub-threshold green.
  localparam pixel_t POS_END  = '{8'd255, 8'd255, 8'd0, 1'b1};
  localparam pixel_t NEG_END  = '{8'd100, 8'd100, 8'd255, 1'b1};
  localparam pixel_t NS_END   = '{8'd30, 8'd255, 8'd30, 1'b1};

  localparam stim_row_t DIRECTED [42] = '{
    // Reset settings: threshold 1.0, high level 0, so every shown pixel is at full end color.
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_0000, 1'b1, PX_BLANK},  // zero magnitude
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0001_0000, 1'b1, PX_BLANK},  // at threshold, hidden
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0001_0001, 1'b1, POS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h7FFF_FFFF, 1'b1, POS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h8000_0000, 1'b1, NEG_END},   // most negative
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'hFFFF_FFFF, 1'b1, PX_BLANK},
    // One-tailed: negative values go blank.
    '{ROW_CFG,  CFG_TWO_TAILED, 48'd0, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'hFFFE_0000, 1'b1, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0002_0000, 1'b1, POS_END},
    // Flip on top of one-tailed; negating the most negative value must stay exact.
    '{ROW_CFG,  CFG_FLIP_SIGN,  48'd1, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'hFFFE_0000, 1'b1, POS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0002_0000, 1'b1, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h8000_0000, 1'b1, POS_END},
    // Sub-threshold display in the ns pair.
    '{ROW_CFG,  CFG_TWO_TAILED, 48'd1, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_FLIP_SIGN,  48'd0, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_SHOW_SUB,   48'd1, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_8000, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0001_0000, 1'b1, NS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_0001, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_0000, 1'b1, PX_BLANK},
    // High level above threshold: real blending.
    '{ROW_CFG,  CFG_HIGH_LEVEL, 48'h0000_0003_0000, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0002_0000, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0003_0000, 1'b1, POS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'hFFFD_8000, 1'b0, PX_BLANK},
    // Zero threshold: every non-zero magnitude is above it.
    '{ROW_CFG,  CFG_THRESHOLD,  48'd0, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_0001, 1'b0, PX_BLANK},
    // Widest threshold and high level, high not above threshold.
    '{ROW_CFG,  CFG_THRESHOLD,  48'h0000_7FFF_FFFF, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_HIGH_LEVEL, 48'h0000_7FFF_FFFF, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h7FFF_FFFF, 1'b1, NS_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h8000_0000, 1'b1, NEG_END},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h4000_0000, 1'b0, PX_BLANK},
    // Most negative high level, a descending positive ramp and rising negative and ns ramps.
    '{ROW_CFG,  CFG_THRESHOLD,  48'd0, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_HIGH_LEVEL, 48'h0000_8000_0000, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_POS_COLORS, 48'hFFFFFF_000000, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_NEG_COLORS, 48'h000000_FFFFFF, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_NS_COLORS,  48'h123456_ABCDEF, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_0005, 1'b1, PX_DARK},
    '{ROW_CFG,  CFG_THRESHOLD,  48'h0000_0001_0000, 32'h0, 1'b0, PX_BLANK},
    '{ROW_CFG,  CFG_HIGH_LEVEL, 48'h0000_0010_0000, 32'h0, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0009_0000, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'hFFF7_0000, 1'b0, PX_BLANK},
    '{ROW_ITEM, CFG_THRESHOLD,  48'd0, 32'h0000_8001, 1'b0, PX_BLANK}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [VALUE_BITS-1:0]   in_value = '0;
  logic                    out_valid;
  logic [CH_BITS-1:0]      out_red;
  logic [CH_BITS-1:0]      out_green;
  logic [CH_BITS-1:0]      out_blue;
  logic                    out_visible;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [COLOR_BITS-1:0]   cfg_data = '0;

  // Hand-typed expectation riding along with the item on the input ports.
  logic                    pin_fixed = 1'b0;
  pixel_t                  pin_px = '0;

  overlay_cfg_t            shadow;
  pixel_t                  pixel_q[$];
  int                      fail_count = 0;
  int                      cycles = 0;
  int                      items_in = 0;
  int                      pixels_out = 0;
  int                      pixels_drawn = 0;
  int                      reg_writes = 0;

  stat_map_overlay_colorizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_visible(out_visible),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic overlay_cfg_t overlay_defaults();
    overlay_cfg_t c;
    c.thr        = THRESHOLD_RST;
    c.high       = '0;
    c.two_tailed = 1'b1;
    c.flip       = 1'b0;
    c.show_sub   = 1'b0;
    c.pos        = POS_COLORS_RST;
    c.neg        = NEG_COLORS_RST;
    c.ns         = NS_COLORS_RST;
    return c;
  endfunction

  // Registers keep only their own width; flags keep bit 0.
  function automatic overlay_cfg_t with_write(overlay_cfg_t c, logic [CFG_IDX_W-1:0] idx,
                                              logic [COLOR_BITS-1:0] data);
    case (idx)
      CFG_THRESHOLD:  c.thr        = data[VALUE_BITS-2:0];
      CFG_HIGH_LEVEL: c.high       = data[VALUE_BITS-1:0];
      CFG_TWO_TAILED: c.two_tailed = data[0];
      CFG_FLIP_SIGN:  c.flip       = data[0];
      CFG_SHOW_SUB:   c.show_sub   = data[0];
      CFG_POS_COLORS: c.pos        = data;
      CFG_NEG_COLORS: c.neg        = data;
      CFG_NS_COLORS:  c.ns         = data;
      default: ;
    endcase
    return c;
  endfunction

  // Restoring division num/den to FRAC_BITS fraction bits, saturating at 1.0.
  function automatic longint unsigned q_fraction(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    int i;
    if (num >= den) return ONE_Q;
    q = 0;
    rem = num;
    for (i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // start + f*(end-start), the product truncated toward zero.
  function automatic logic [CH_BITS-1:0] blend_channel(logic [COLOR_BITS-1:0] pair, int shift,
                                                       longint unsigned f);
    longint s;
    longint e;
    longint prod;
    longint step;
    s = pair[shift+24 +: 8];
    e = pair[shift +: 8];
    prod = longint'(f) * (e - s);
    step = (prod < 0) ? -((-prod) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
    return CH_BITS'(s + step);
  endfunction

  function automatic pixel_t colorize(overlay_cfg_t c, logic [VALUE_BITS-1:0] value);
    longint v;
    longint mag;
    longint thr;
    longint high;
    longint unsigned f;
    logic [COLOR_BITS-1:0] pair;
    pixel_t px;
    px = PX_BLANK;
    // Widen before negation so the most negative value flips exactly.
    v = longint'($signed(value));
    thr = longint'(c.thr);
    high = longint'($signed(c.high));
    if (c.flip) v = -v;
    if (!c.two_tailed && v < 0) return px;
    mag = (v < 0) ? -v : v;
    if (mag == 0) return px;
    if (mag > thr) begin
      f = (high <= thr) ? ONE_Q : q_fraction(mag - thr, high - thr);
      pair = (v >= 0) ? c.pos : c.neg;
    end else begin
      if (!c.show_sub) return px;
      f = q_fraction(mag, thr);
      pair = c.ns;
    end
    px.red     = blend_channel(pair, 16, f);
    px.green   = blend_channel(pair, 8, f);
    px.blue    = blend_channel(pair, 0, f);
    px.visible = 1'b1;
    return px;
  endfunction

  // ---------------------------------------------------------------- monitor and checker

  // Sample everything at the rising edge: check the result first, then log the
  // accepted item against the settings in force, then track any register write.
  always @(posedge clk) begin
    pixel_t want;
    cycles++;
    if (!rst_n) begin
      shadow = overlay_defaults();
      pixel_q.delete();
    end else begin
      if (out_valid) begin
        pixels_out++;
        if (out_visible) pixels_drawn++;
        if (pixel_q.size() == 0) begin
          $error("result with no item outstanding: r=%0d g=%0d b=%0d visible=%0d",
                 out_red, out_green, out_blue, out_visible);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (out_red !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, out_red);
            fail_count++;
          end
          if (out_green !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, out_green);
            fail_count++;
          end
          if (out_blue !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
            fail_count++;
          end
          if (out_visible !== want.visible) begin
            $error("out_visible: expected %0d, got %0d", want.visible, out_visible);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pixel_q.insert(pixel_q.size(), pin_fixed ? pin_px : colorize(shadow, in_value));
        items_in++;
      end
      if (cfg_we) begin
        shadow = with_write(shadow, cfg_index, cfg_data);
        reg_writes++;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pixel_q.size());
      $display("stat_map_overlay_colorizer_unit_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Every task is entered and left at a falling edge.

  // Hold start and the item until the handshake edge; drop any open register write.
  task automatic send_item(input logic [VALUE_BITS-1:0] value, input logic fixed,
                           input pixel_t px, input int gap);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    in_value  <= value;
    pin_fixed <= fixed;
    pin_px    <= px;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding result has been checked.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pixel_q.size() != 0);
  endtask

  // Leave the write enable up; the next item lowers it, so back-to-back writes stay clean.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  function automatic logic [COLOR_BITS-1:0] wide_noise();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [COLOR_BITS-1:0] rand_colors();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return wide_noise();
    endcase
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Aim most values near the threshold or inside the blend ramp, where the divider works.
  function automatic logic [VALUE_BITS-1:0] rand_value(overlay_cfg_t c);
    longint thr;
    longint high;
    longint mag;
    thr = longint'(c.thr);
    high = longint'($signed(c.high));
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4: mag = thr + longint'($urandom_range(0, 512)) - 256;
      5, 6, 7: begin
        if (high > thr) mag = thr + longint'($urandom_range(0, 32'(high - thr)));
        else mag = thr + longint'($urandom_range(0, 32'h1_0000));
      end
      8: mag = longint'($urandom_range(0, 32'(thr)));
      default: begin
        case ($urandom_range(0, 4))
          0:       mag = 0;
          1:       mag = 1;
          2:       mag = 64'h8000_0000;
          3:       mag = high;
          default: mag = thr;
        endcase
      end
    endcase
    if (mag < 0) mag = -mag;
    return VALUE_BITS'(($urandom_range(0, 1) != 0) ? -mag : mag);
  endfunction

  // Write all eight registers; the first two phases pin the threshold and high level
  // to their extremes and set the flags; non-color writes carry junk in unused bits.
  task automatic program_setting(input int phase);
    logic [VALUE_BITS-2:0] thr;
    logic [VALUE_BITS-1:0] high;
    logic [COLOR_BITS-1:0] thr_d;
    logic [COLOR_BITS-1:0] high_d;
    logic [COLOR_BITS-1:0] two_d;
    logic [COLOR_BITS-1:0] flip_d;
    logic [COLOR_BITS-1:0] sub_d;
    case ($urandom_range(0, 4))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = (VALUE_BITS-1)'($urandom_range(1, 32'h4_0000));
      3:       thr = (VALUE_BITS-1)'($urandom);
      default: thr = (VALUE_BITS-1)'($urandom_range(32'h100, 32'h20_0000));
    endcase
    case ($urandom_range(0, 5))
      0:       high = VALUE_BITS'(thr) - $urandom_range(0, 32'h1000);
      1:       high = 32'h7FFF_FFFF;
      2:       high = 32'h8000_0000;
      3:       high = VALUE_BITS'(thr) + $urandom_range(1, 32'h4_0000);
      4:       high = $urandom;
      default: high = VALUE_BITS'(thr) + $urandom_range(1, 32'h40_0000);
    endcase
    thr_d  = wide_noise();
    high_d = wide_noise();
    two_d  = wide_noise();
    flip_d = wide_noise();
    sub_d  = wide_noise();
    if (phase == 0) begin
      thr = '0;
      high = 32'h7FFF_FFFF;
      two_d[0] = 1'b1;
      flip_d[0] = 1'b0;
      sub_d[0] = 1'b1;
    end else if (phase == 1) begin
      thr = '1;
      high = 32'h8000_0000;
      two_d[0] = 1'b0;
      flip_d[0] = 1'b1;
      sub_d[0] = 1'b1;
    end
    thr_d[VALUE_BITS-2:0]  = thr;
    high_d[VALUE_BITS-1:0] = high;
    write_reg(CFG_THRESHOLD, thr_d);
    write_reg(CFG_HIGH_LEVEL, high_d);
    write_reg(CFG_TWO_TAILED, two_d);
    write_reg(CFG_FLIP_SIGN, flip_d);
    write_reg(CFG_SHOW_SUB, sub_d);
    write_reg(CFG_POS_COLORS, rand_colors());
    write_reg(CFG_NEG_COLORS, rand_colors());
    write_reg(CFG_NS_COLORS, rand_colors());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    bit last_cfg;
    int p;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table. Drain before each group of register writes so the
    // block is idle whenever a setting changes.
    last_cfg = 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        if (!last_cfg) wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
        last_cfg = 1'b1;
      end else begin
        send_item(DIRECTED[i].value, DIRECTED[i].fixed, DIRECTED[i].px, draw_gap(2));
        last_cfg = 1'b0;
      end
    end

    // Random phases: drain, reprogram every register, then stream items. Rotate the
    // sender between back-to-back, random gaps and occasional gaps.
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      program_setting(p);
      repeat (ITEMS_PER_PHASE) send_item(rand_value(shadow), 1'b0, PX_BLANK, draw_gap(p % 3));
    end

    // Drain, then give any stray result time to show up.
    wait_idle();
    repeat (LATENCY + 4) @(negedge clk);

    $display("covered %0d items (%0d directed rows) under %0d register writes",
             items_in, $size(DIRECTED), reg_writes);
    $display("checked %0d pixels, %0d drawn, %0d mismatches", pixels_out, pixels_drawn,
             fail_count);
    if (fail_count == 0) begin
      $display("stat_map_overlay_colorizer_unit_tb: PASS");
    end else begin
      $display("stat_map_overlay_colorizer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/smoc_pkg.sv
rtl/core/stat_map_overlay_colorizer_unit.sv
tb/stat_map_overlay_colorizer_unit_tb.sv
